/* design/binary_row_shift_match_scorer_macros.svh */
// Assertion macros for the checker file.
`ifndef BINARY_ROW_SHIFT_MATCH_SCORER_MACROS_SVH
`define BINARY_ROW_SHIFT_MATCH_SCORER_MACROS_SVH

// Clocked check, off while reset is held.
`define BRSMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked check that also holds while reset is asserted.
`define BRSMS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* design/brsms_pkg.sv */
package brsms_pkg;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ROWS_W  = 10;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned MATCH_W = 18;

  // Largest total over the whole ROW_BYTES range (1023 rows of 512 bits)
  localparam int unsigned ROWS_MAX     = 1023;
  localparam int unsigned MAX_ROW_BITS = 512;
  localparam int unsigned TOTAL_W      = $clog2(ROWS_MAX * MAX_ROW_BITS + 1);

  // Percentage scale
  localparam int unsigned SCALE_W = 7;
  localparam logic [SCALE_W-1:0] PCT_SCALE = 7'd100;

  // Job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Register map
  localparam int unsigned APB_ADDR_W = 2;
  localparam logic [APB_ADDR_W-1:0] ADDR_ROW_COUNT = 2'd0;

  typedef logic [TOTAL_W-1:0] total_t;

  typedef struct packed {
    logic [PCT_W-1:0]   pct;
    logic [MATCH_W-1:0] match;
  } result_t;

  function automatic logic [3:0] popcnt8(input logic [BYTE_W-1:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      n = n + {3'b000, v[i]};
    end
    return n;
  endfunction

endpackage

/* design/brsms_front.sv */
module brsms_front
  import brsms_pkg::*;
#(
  parameter int unsigned ROW_BYTES = 20,
  parameter int unsigned MAX_SHIFT = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] byte_a_i,
  input  logic [BYTE_W-1:0] byte_b_i,
  input  logic              row_end_i,
  input  logic              image_end_i,
  input  logic [ROWS_W-1:0] row_count_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output total_t            push_total_o
);

  localparam int unsigned ROW_BITS = ROW_BYTES * 8;
  localparam int unsigned CNT_W    = $clog2(ROW_BITS + 1);
  localparam int unsigned N_SH     = 2 * MAX_SHIFT + 1;
  localparam logic [CNT_W-1:0] ROW_BITS_C = CNT_W'(ROW_BITS);

  typedef enum logic [4:0] {
    F_IDLE  = 5'b00001,
    F_FLUSH = 5'b00010,
    F_MIN   = 5'b00100,
    F_ADD   = 5'b01000,
    F_PUSH  = 5'b10000
  } front_state_e;

  front_state_e state_q;

  logic [BYTE_W-1:0] held_a_q, held_b_q, earlier_q;
  logic              pending_q;
  logic              image_q;
  logic [CNT_W-1:0]  cnt_q   [N_SH];
  logic [CNT_W-1:0]  cnt_d   [N_SH];
  logic [CNT_W-1:0]  cnt_sat [N_SH];
  logic [CNT_W-1:0]  best_q, best_d;
  logic [ROWS_W-1:0] rows_q;
  total_t            total_q;

  logic              accept;
  logic              score_en;
  logic [BYTE_W-1:0] right_b;
  logic [3*BYTE_W-1:0] win;

  assign in_ready_o   = (state_q == F_IDLE);
  assign accept       = in_valid_i & in_ready_o;
  assign push_valid_o = (state_q == F_PUSH);
  assign push_total_o = total_q;

  // right neighbor is the incoming byte, or zero fill at the row edge
  assign right_b  = (state_q == F_FLUSH) ? '0 : byte_b_i;
  assign win      = {earlier_q, held_b_q, right_b};
  assign score_en = pending_q & ((accept) | (state_q == F_FLUSH));

  // one lane per shift: s > 0 moves pixels left
  for (genvar k = 0; k < N_SH; k++) begin : g_lane
    localparam int S = k - int'(MAX_SHIFT);
    logic [BYTE_W-1:0] shifted;
    logic [CNT_W:0]    sum;
    assign shifted = win[15-S -: 8];
    assign sum = {1'b0, cnt_q[k]} + (CNT_W+1)'(popcnt8(held_a_q ^ shifted));
    assign cnt_sat[k] = (sum > {1'b0, ROW_BITS_C}) ? ROW_BITS_C : sum[CNT_W-1:0];
  end

  always_comb begin
    for (int k = 0; k < N_SH; k++) begin
      cnt_d[k] = cnt_q[k];
      if (score_en) begin
        cnt_d[k] = cnt_sat[k];
      end
      if (state_q == F_MIN) begin
        cnt_d[k] = '0;
      end
    end
  end

  always_comb begin
    best_d = ROW_BITS_C;
    for (int k = 0; k < N_SH; k++) begin
      if (cnt_q[k] < best_d) begin
        best_d = cnt_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      held_a_q  <= '0;
      held_b_q  <= '0;
      earlier_q <= '0;
      pending_q <= 1'b0;
      image_q   <= 1'b0;
      best_q    <= '0;
      rows_q    <= '0;
      total_q   <= '0;
      for (int k = 0; k < N_SH; k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      for (int k = 0; k < N_SH; k++) begin
        cnt_q[k] <= cnt_d[k];
      end
      unique case (state_q)
        F_IDLE: begin
          if (accept) begin
            if (pending_q) begin
              earlier_q <= held_b_q;
            end
            held_a_q  <= byte_a_i;
            held_b_q  <= byte_b_i;
            pending_q <= 1'b1;
            image_q   <= image_end_i;
            if (row_end_i || image_end_i) begin
              state_q <= F_FLUSH;
            end
          end
        end
        F_FLUSH: begin
          // last byte scored against zero fill, row state back to start
          held_a_q  <= '0;
          held_b_q  <= '0;
          earlier_q <= '0;
          pending_q <= 1'b0;
          state_q   <= F_MIN;
        end
        F_MIN: begin
          best_q  <= best_d;
          state_q <= F_ADD;
        end
        F_ADD: begin
          if (rows_q < row_count_i) begin
            total_q <= total_q + TOTAL_W'(ROW_BITS_C - best_q);
            rows_q  <= rows_q + ROWS_W'(1);
          end
          state_q <= image_q ? F_PUSH : F_IDLE;
        end
        F_PUSH: begin
          if (push_ready_i) begin
            total_q <= '0;
            rows_q  <= '0;
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

/* design/brsms_fifo.sv */
module brsms_fifo
  import brsms_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_valid_i,
  output logic   wr_ready_o,
  input  total_t wr_data_i,
  output logic   rd_valid_o,
  input  logic   rd_ready_i,
  output total_t rd_data_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  total_t           mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_wr, do_rd;

  assign wr_ready_o = (cnt_q != FULL_CNT);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rptr_q];
  assign do_wr      = wr_valid_i & wr_ready_o;
  assign do_rd      = rd_valid_o & rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + PTR_W'(1);
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + PTR_W'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* design/brsms_back.sv */
module brsms_back
  import brsms_pkg::*;
#(
  parameter int unsigned ROW_BYTES = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  total_t            job_total_i,
  input  logic [ROWS_W-1:0] row_count_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output result_t           res_o
);

  localparam int unsigned ROW_BITS  = ROW_BYTES * 8;
  localparam int unsigned REM_W     = TOTAL_W + SCALE_W;
  localparam int unsigned DIV_SHIFT = PCT_W - 1;
  localparam int unsigned STEP_W    = $clog2(PCT_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_SHIFT);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_DONE = 3'b100
  } back_state_e;

  back_state_e state_q;

  logic [REM_W-1:0]   rem_q, dvs_q;
  logic [PCT_W-1:0]   quo_q;
  logic [STEP_W-1:0]  step_q;
  logic               zero_q;
  logic [MATCH_W-1:0] match_q;
  logic               res_valid_q;
  result_t            res_q;
  logic               ge;

  assign job_ready_o = (state_q == B_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign ge          = (rem_q >= dvs_q);

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: begin
        rem_q   <= REM_W'(job_total_i) * REM_W'(PCT_SCALE);
        dvs_q   <= (REM_W'(row_count_i) * REM_W'(ROW_BITS)) << DIV_SHIFT;
        zero_q  <= (row_count_i == '0);
        match_q <= job_total_i[MATCH_W-1:0];
        quo_q   <= '0;
      end
      B_DIV: begin
        if (ge) begin
          rem_q <= rem_q - dvs_q;
        end
        dvs_q <= dvs_q >> 1;
        quo_q <= {quo_q[PCT_W-2:0], ge};
      end
      B_DONE: begin
        rem_q <= rem_q;
      end
      default: rem_q <= rem_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == B_DONE) && (!res_valid_q || res_ready_i)) begin
      res_q.pct   <= zero_q ? '0 : quo_q;
      res_q.match <= match_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      step_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (res_valid_q && res_ready_i) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          step_q <= '0;
          if (job_valid_i) begin
            state_q <= B_DIV;
          end
        end
        B_DIV: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == LAST_STEP) begin
            state_q <= B_DONE;
          end
        end
        B_DONE: begin
          if (!res_valid_q || res_ready_i) begin
            res_valid_q <= 1'b1;
            state_q     <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

/* design/binary_row_shift_match_scorer.sv */
// Row-by-row similarity scorer for two 1-bit images. Each input transfer
// carries one byte of image A and the matching byte of image B (MSB is the
// leftmost pixel); tlast marks the last byte of a row and tuser the last byte
// of the image. Every row of B is compared against A at shifts -MAX_SHIFT to
// +MAX_SHIFT with zero fill at the row edges, and the best matching-bit count
// of the first row_count rows is summed. After the image end one result
// transfer gives that sum and the truncated percentage sum*100 /
// (row_count*ROW_BYTES*8), zero when row_count is 0. Throughput: one byte per
// cycle inside a row; the byte that closes a row holds the input through the
// edge flush, the minimum search over the shift counters and the accumulate,
// and, when it ends the image, through the hand-off to the job queue, which can
// wait on a full queue. The result side runs a 7-step restoring divider behind
// a 2-entry queue and an output register, so it overlaps the next image.
// The user writes row_count over APB, byte address 0, only while idle; unchecked.
module binary_row_shift_match_scorer
  import brsms_pkg::*;
#(
  parameter int unsigned ROW_BYTES = 20,  // 2..64
  parameter int unsigned MAX_SHIFT = 3    // 1..7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,  // [7:0] byte_a, [15:8] byte_b
  input  logic                  s_axis_tlast,  // row_end
  input  logic                  s_axis_tuser,  // image_end
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata,  // [6:0] similarity_percent,
                                               // [24:7] matching_bits, rest 0
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [ROWS_W-1:0] row_count_q;
  logic              cfg_wr;

  // front to queue
  logic   push_valid, push_ready;
  total_t push_total;
  // queue to back
  logic   job_valid, job_ready;
  total_t job_total;

  result_t res;

  // ---------------------------------------------------------------------
  // Configuration: single register, zero wait states
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr == ADDR_ROW_COUNT);
  assign prdata = (paddr == ADDR_ROW_COUNT) ? {{(32-ROWS_W){1'b0}}, row_count_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= '0;
    end else if (cfg_wr) begin
      row_count_q <= pwdata[ROWS_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Front: per-byte shift scoring and row accumulation
  // ---------------------------------------------------------------------
  brsms_front #(
    .ROW_BYTES (ROW_BYTES),
    .MAX_SHIFT (MAX_SHIFT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .byte_a_i     (s_axis_tdata[7:0]),
    .byte_b_i     (s_axis_tdata[15:8]),
    .row_end_i    (s_axis_tlast),
    .image_end_i  (s_axis_tuser),
    .row_count_i  (row_count_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_total_o (push_total)
  );

  // ---------------------------------------------------------------------
  // Job queue: one entry per finished image
  // ---------------------------------------------------------------------
  brsms_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  (push_total),
    .rd_valid_o (job_valid),
    .rd_ready_i (job_ready),
    .rd_data_o  (job_total)
  );

  // ---------------------------------------------------------------------
  // Back: percentage divider and output register
  // ---------------------------------------------------------------------
  brsms_back #(
    .ROW_BYTES (ROW_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_total_i (job_total),
    .row_count_i (row_count_q),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {{(32-PCT_W-MATCH_W){1'b0}}, res.match, res.pct};

endmodule

/* design/brsms_sva.sv */
`include "binary_row_shift_match_scorer_macros.svh"

module brsms_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // images ended at the input but not yet delivered
  logic [3:0] open_q;
  logic       img_in, res_out;

  assign img_in  = s_axis_tvalid & s_axis_tready & s_axis_tuser;
  assign res_out = m_axis_tvalid & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      case ({img_in, res_out})
        2'b10:   open_q <= open_q + 4'd1;
        2'b01:   open_q <= open_q - 4'd1;
        default: open_q <= open_q;
      endcase
    end
  end

  `BRSMS_ASSERT(a_no_spurious_result, m_axis_tvalid |-> open_q != 4'd0, "result without image end")

  `BRSMS_ASSERT(a_row_close_stalls, s_axis_tvalid && s_axis_tready && (s_axis_tlast || s_axis_tuser) |=> !s_axis_tready, "input not stalled after row close")

  `BRSMS_ASSERT(a_pad_zero, m_axis_tvalid |-> m_axis_tdata[31:25] == 7'd0, "result padding not zero")

  `BRSMS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  `BRSMS_ASSERT_RST(a_reset_quiet, !rst_ni |-> !m_axis_tvalid, "result valid during reset")

endmodule

bind binary_row_shift_match_scorer brsms_sva u_sva (.*);

/* verif/tb_binary_row_shift_match_scorer.sv */
`timescale 1ns / 1ps

module tb_binary_row_shift_match_scorer;
  import brsms_pkg::*;

  // Must match the DUT parameters below
  localparam int unsigned ROW_BYTES  = 20;
  localparam int unsigned MAX_SHIFT  = 3;
  localparam int unsigned NUM_SHIFTS = 2 * MAX_SHIFT + 1;
  localparam int unsigned ROW_BITS   = ROW_BYTES * 8;

  // Longest row the stimulus builds; past 32 bytes an 8-bit counter would wrap
  localparam int unsigned MAX_ROW_LEN = 40;
  localparam int unsigned ROW_VEC_W   = MAX_ROW_LEN * 8;

  // Settle time covers the row end steps, image hand-off, divider, queue and output reg
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned HOLD_OFF_CYCLES = 500;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned IMAGES_PER_SET  = 2;

  // row_count plan: two settings per idling phase
  localparam int RANDOM_ROWS = -1;
  localparam int ROW_COUNT_PLAN [8] = '{3, 1023, 1, 2, 0, RANDOM_ROWS, 5, RANDOM_ROWS};
  // idling plan in percent: none, sender, receiver, both
  localparam int unsigned SEND_IDLE_PLAN [4] = '{0, 80, 0, 28};
  localparam int unsigned STALL_PLAN     [4] = '{0, 0, 80, 28};

  typedef enum {FILL_RANDOM, FILL_EQUAL, FILL_SHIFTED, FILL_INVERTED, FILL_SOLID} fill_e;

  // Tracks the scorer's row state and keeps the expected image scores
  class similarity_scoreboard;
    logic [ROWS_W-1:0]  row_limit;
    logic [BYTE_W-1:0]  held_a;
    logic [BYTE_W-1:0]  held_b;
    logic [BYTE_W-1:0]  left_b;
    bit                 pair_held;
    logic [7:0]         diff_cnt [NUM_SHIFTS];
    logic [ROWS_W-1:0]  rows_scored;
    logic [MATCH_W-1:0] match_sum;
    result_t            expected_scores [$];
    int unsigned        error_count;

    function new();
      row_limit   = '0;
      rows_scored = '0;
      match_sum   = '0;
      error_count = 0;
      clear_row();
    endfunction

    function void clear_row();
      held_a    = '0;
      held_b    = '0;
      left_b    = '0;
      pair_held = 1'b0;
      foreach (diff_cnt[k]) diff_cnt[k] = '0;
    endfunction

    function void set_row_limit(input logic [ROWS_W-1:0] value);
      row_limit = value;
    endfunction

    // One byte of A against every shift of B; right/left neighbors feed the fill
    function void score_byte(input logic [7:0] a, input logic [7:0] cur,
                             input logic [7:0] left, input logic [7:0] right);
      logic [15:0] pair;
      logic [7:0]  shifted;
      int unsigned sum;
      for (int s = -int'(MAX_SHIFT); s <= int'(MAX_SHIFT); s++) begin
        if (s > 0) begin
          pair    = {cur, right} << s;
          shifted = pair[15:8];
        end else if (s < 0) begin
          pair    = {left, cur} >> (-s);
          shifted = pair[7:0];
        end else begin
          shifted = cur;
        end
        sum = diff_cnt[s + int'(MAX_SHIFT)] + $countones(a ^ shifted);
        diff_cnt[s + int'(MAX_SHIFT)] = (sum > ROW_BITS) ? 8'(ROW_BITS) : 8'(sum);
      end
    endfunction

    function void close_row();
      int unsigned best;
      best = ROW_BITS;
      if (pair_held) score_byte(held_a, held_b, left_b, 8'h00);
      foreach (diff_cnt[k]) begin
        if (diff_cnt[k] < best) best = diff_cnt[k];
      end
      // rows past row_count are scored but not added
      if (rows_scored < row_limit) begin
        match_sum   += MATCH_W'(ROW_BITS - best);
        rows_scored += 1'b1;
      end
      clear_row();
    endfunction

    function void note_byte_pair(input logic [7:0] a, input logic [7:0] b,
                                 input logic row_end, input logic image_end);
      longint unsigned denom;
      longint unsigned pct;
      result_t         score;
      if (pair_held) begin
        score_byte(held_a, held_b, left_b, b);
        left_b = held_b;
      end
      held_a    = a;
      held_b    = b;
      pair_held = 1'b1;
      // image end closes the row even without row end
      if (row_end || image_end) close_row();
      if (image_end) begin
        denom = longint'(row_limit) * ROW_BITS;
        pct   = (denom == 0) ? 0 : (longint'(match_sum) * 100) / denom;
        score.pct   = PCT_W'(pct);
        score.match = match_sum;
        expected_scores.push_back(score);
        rows_scored = '0;
        match_sum   = '0;
      end
    endfunction

    function void check_score(input logic [31:0] tdata);
      result_t            want;
      logic [PCT_W-1:0]   got_pct;
      logic [MATCH_W-1:0] got_match;
      got_pct   = tdata[PCT_W-1:0];
      got_match = tdata[PCT_W +: MATCH_W];
      if (expected_scores.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual pct=%0d match=%0d",
                 $time, got_pct, got_match);
        error_count++;
        return;
      end
      want = expected_scores.pop_front();
      if (got_pct !== want.pct) begin
        $display("%0t: similarity_percent mismatch: expected %0d, actual %0d",
                 $time, want.pct, got_pct);
        error_count++;
      end
      if (got_match !== want.match) begin
        $display("%0t: matching_bits mismatch: expected %0d, actual %0d",
                 $time, want.match, got_match);
        error_count++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata;   // [7:0] byte_a, [15:8] byte_b
  logic                  s_axis_tlast;   // row_end
  logic                  s_axis_tuser;   // image_end
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [31:0]           m_axis_tdata;   // [6:0] similarity_percent, [24:7] matching_bits
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  similarity_scoreboard score_ref = new();

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_cycles_left;
  int unsigned cycle_count;

  // Current row contents, byte 0 in the top bits, MSB of each byte leftmost
  logic [ROW_VEC_W-1:0] row_a_bits;
  logic [ROW_VEC_W-1:0] row_b_bits;

  binary_row_shift_match_scorer #(
    .ROW_BYTES(ROW_BYTES),
    .MAX_SHIFT(MAX_SHIFT)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hang or a lost transfer ends here
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Both streams are sampled at the edge, before the NBA updates of that step
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        score_ref.note_byte_pair(s_axis_tdata[7:0], s_axis_tdata[15:8],
                                 s_axis_tlast, s_axis_tuser);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        score_ref.check_score(m_axis_tdata);
      end
    end
  end

  // Result side: random stalls, plus a long hold-off when one is requested
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_cycles_left != 0) begin
        hold_cycles_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // One input transfer; random idle cycles go in front of it.
  // tvalid stays high between back-to-back transfers.
  task automatic send_pair(input logic [7:0] a, input logic [7:0] b,
                           input logic row_end, input logic image_end);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    s_axis_tlast  <= row_end;
    s_axis_tuser  <= image_end;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // APB write of row_count, then read it back
  task automatic write_row_count(input logic [ROWS_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ROW_COUNT;
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    score_ref.set_row_limit(value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(value)) begin
      $display("%0t: row_count readback mismatch: expected %0d, actual %0d",
               $time, value, prdata);
      score_ref.error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stop the input, wait for every expected score, then let the block settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (score_ref.expected_scores.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Fill row_a_bits/row_b_bits for a row of len bytes
  task automatic build_row(input int unsigned len);
    logic [ROW_VEC_W-1:0] row_mask;
    int                   shift_by;
    int unsigned          pick;
    int unsigned          flip_at;
    fill_e                fill;
    row_mask = '1;
    row_mask = row_mask << ((MAX_ROW_LEN - len) * 8);
    for (int w = 0; w < ROW_VEC_W / 32; w++) begin
      row_a_bits[w*32 +: 32] = $urandom();
      row_b_bits[w*32 +: 32] = $urandom();
    end
    // pixels past the row edge must be zero, else a shift drags them in
    row_a_bits &= row_mask;
    pick = $urandom_range(0, 9);
    fill = (pick < 2) ? FILL_RANDOM : (pick < 4) ? FILL_EQUAL :
           (pick < 8) ? FILL_SHIFTED : (pick < 9) ? FILL_INVERTED : FILL_SOLID;
    case (fill)
      FILL_EQUAL: begin
        row_b_bits = row_a_bits;
      end
      FILL_SHIFTED: begin
        // B is A moved by up to 4 pixels, a little past the search window
        shift_by = int'($urandom_range(0, 8)) - 4;
        if (shift_by >= 0) row_b_bits = row_a_bits << shift_by;
        else row_b_bits = row_a_bits >> (-shift_by);
        repeat ($urandom_range(0, 3)) begin
          flip_at = ROW_VEC_W - 1 - $urandom_range(0, len * 8 - 1);
          row_b_bits[flip_at] = ~row_b_bits[flip_at];
        end
      end
      FILL_INVERTED: begin
        row_b_bits = ~row_a_bits;
      end
      FILL_SOLID: begin
        // solid opposite rows: bits differ but where zero fill meets a zero A; long rows saturate
        if ($urandom_range(0, 1) != 0) begin
          row_a_bits = '1;
          row_b_bits = '0;
        end else begin
          row_a_bits = '0;
          row_b_bits = '1;
        end
      end
      default: begin
      end
    endcase
  endtask

  // Tidy images have full rows and row ends, but image end may lack one; the
  // rest have odd row lengths, stray row ends and image end without row end.
  task automatic send_image(input int unsigned rows, input bit tidy);
    int unsigned len;
    logic        row_end;
    logic        image_end;
    for (int r = 0; r < int'(rows); r++) begin
      len = tidy ? ROW_BYTES : $urandom_range(1, MAX_ROW_LEN);
      build_row(len);
      for (int j = 0; j < int'(len); j++) begin
        image_end = (r == int'(rows) - 1) && (j == int'(len) - 1);
        if (j == int'(len) - 1) begin
          row_end = tidy ? (!image_end || $urandom_range(0, 9) != 0)
                         : ($urandom_range(0, 3) != 0);
        end else begin
          row_end = !tidy && ($urandom_range(0, 19) == 0);
        end
        send_pair(row_a_bits[(MAX_ROW_LEN - 1 - j) * 8 +: 8],
                  row_b_bits[(MAX_ROW_LEN - 1 - j) * 8 +: 8], row_end, image_end);
      end
    end
  endtask

  initial begin
    int         plan;
    rst_ni           = 1'b0;
    s_axis_tvalid    = 1'b0;
    s_axis_tdata     = '0;
    s_axis_tlast     = 1'b0;
    s_axis_tuser     = 1'b0;
    m_axis_tready    = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    send_idle_pct    = 0;
    stall_pct        = 0;
    hold_cycles_left = 0;
    cycle_count      = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: row_count still at its reset value 0, so everything scores 0
    send_pair(8'h00, 8'h00, 1'b1, 1'b1);
    wait_idle();
    write_row_count(10'd2);
    // short rows, a third row past row_count, image end without row end
    send_pair(8'hFF, 8'hFF, 1'b0, 1'b0);
    send_pair(8'hFF, 8'h00, 1'b1, 1'b0);
    send_pair(8'h81, 8'h18, 1'b1, 1'b0);
    send_pair(8'h7F, 8'hFE, 1'b0, 1'b1);
    // one-byte image
    send_pair(8'hAA, 8'h55, 1'b1, 1'b1);
    // single two-byte row closed only by image end
    send_pair(8'hF0, 8'h0F, 1'b0, 1'b0);
    send_pair(8'h0F, 8'hF0, 1'b0, 1'b1);
    // row longer than ROW_BYTES, all bits different at every shift
    for (int j = 0; j < 24; j++) begin
      send_pair(8'hFF, 8'h00, 1'b0, j == 23);
    end
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = SEND_IDLE_PLAN[ph];
      stall_pct     = STALL_PLAN[ph];
      for (int sub = 0; sub < 2; sub++) begin
        plan = ROW_COUNT_PLAN[ph * 2 + sub];
        if (plan == RANDOM_ROWS) write_row_count(ROWS_W'($urandom_range(0, 1023)));
        else write_row_count(ROWS_W'(plan));

        if (ph == 0 && sub == 0) begin
          // Receiver holds off while tiny images keep coming: the result
          // queue fills and the input side has to stall.
          hold_cycles_left = HOLD_OFF_CYCLES;
          repeat (12) begin
            if ($urandom_range(0, 1) != 0) send_pair(8'($urandom()), 8'($urandom()), 1'b0, 1'b0);
            send_pair(8'($urandom()), 8'($urandom()), 1'($urandom()), 1'b1);
          end
        end

        repeat (IMAGES_PER_SET) begin
          send_image($urandom_range(1, 3), $urandom_range(0, 99) < 85);
        end
        wait_idle();
      end
    end

    if (score_ref.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
